// ===== rtl/core/spms_pkg.sv =====
// ----------------------------------------------------------------------------
// spms_pkg: shared pool multi-stack package
// Sizes, operation and status codes and controller states shared by the
// shared pool multi-stack core.
// ----------------------------------------------------------------------------
package spms_pkg;

  // pool geometry
  localparam int NUM_STACKS = 4;
  localparam int POOL_SLOTS = 64;
  localparam int DATA_WIDTH = 32;

  // fixed field widths of the request and response
  localparam int MODE_W   = 2;
  localparam int SEL_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // derived widths: slot index, and slot pointer that can also hold the end marker
  localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int PTR_W = $clog2(POOL_SLOTS + 1);
  localparam int STK_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  localparam logic [PTR_W-1:0] END_MARK = PTR_W'(POOL_SLOTS);

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  // operation codes; the spare code is a no-operation
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_NOP  = 2'd3
  } mode_e;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // a pointer names a slot only below the end marker
  function automatic logic is_slot(input ptr_t p);
    return p < END_MARK;
  endfunction

endpackage

// ===== rtl/core/shared_pool_multi_stack_core.sv =====
// ----------------------------------------------------------------------------
// shared_pool_multi_stack_core: several stacks in one shared slot pool
// Push, pop and peek on any of the stacks; free slots sit on a linked list.
// ----------------------------------------------------------------------------
// Usage:
//   A request (mode_i, stack_sel_i, push_value_i) is taken at a rising edge
//   where start_i is high and busy_o is low. Each transaction yields exactly
//   one response on read_value_o, status_o, stack_now_empty_o and
//   pool_now_full_o, valid for one cycle while done_o is high.
//   The accepting edge moves the core to the execution state, where the
//   response is formed; it is registered as that state ends and then driven.
//   A new request is not taken until the previous one has executed. The
//   accepting edge reads the slot data and slot link memories; the
//   execution state updates heads, writes back the memories and registers
//   the response. busy_o is high in the execution state only, so a new
//   request may be started in the cycle the previous response is shown.
//   Reset: all stacks empty, every slot on the free list in order. The link
//   memory is covered by per-entry valid bits, so no clearing pass is run
//   and requests are taken straight after reset.
//   The receiver cannot stall: done_o is a one-cycle strobe.
// ----------------------------------------------------------------------------
module shared_pool_multi_stack_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [spms_pkg::MODE_W-1:0]    mode_i,
  input  logic [spms_pkg::SEL_W-1:0]     stack_sel_i,
  input  logic [spms_pkg::VALUE_W-1:0]   push_value_i,
  output logic                           done_o,
  output logic [spms_pkg::VALUE_W-1:0]   read_value_o,
  output logic [spms_pkg::STATUS_W-1:0]  status_o,
  output logic                           stack_now_empty_o,
  output logic                           pool_now_full_o
);
  import spms_pkg::*;

  // memories
  data_t data_mem [POOL_SLOTS];
  ptr_t  link_mem [POOL_SLOTS];
  logic [POOL_SLOTS-1:0] link_vld_q;

  // control state
  state_e state_q, state_d;
  ptr_t   stack_head_q [NUM_STACKS];
  ptr_t   stack_head_d [NUM_STACKS];
  ptr_t   free_head_q, free_head_d;

  // latched request
  logic [MODE_W-1:0] mode_q;
  logic [STK_W-1:0]  sel_q;
  logic              sel_ok_q;
  data_t             value_q;

  // memory read side
  data_t data_rd_q;
  ptr_t  link_rd_q;
  logic  link_vld_rd_q;
  idx_t  link_rd_idx_q;
  ptr_t  link_rd;

  // memory write side
  logic  data_we, link_we;
  idx_t  data_wa, link_wa;
  data_t data_wd;
  ptr_t  link_wd;

  // response registers
  logic                done_q, done_d;
  logic [VALUE_W-1:0]  rd_val_q, rd_val_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                now_empty_q, now_empty_d;
  logic                now_full_q, now_full_d;

  logic accept;
  logic sel_ok;
  ptr_t top_in, top_q, link_ra;
  idx_t link_ra_idx;

  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign sel_ok  = 32'(stack_sel_i) < NUM_STACKS;

  // top of the addressed stack at request time and during execution
  assign top_in      = sel_ok ? stack_head_q[STK_W'(stack_sel_i)] : END_MARK;
  assign top_q       = stack_head_q[sel_q];
  assign link_ra     = (mode_e'(mode_i) == MODE_PUSH) ? free_head_q : top_in;
  assign link_ra_idx = IDX_W'(link_ra);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // link read: unwritten entries still hold their reset chain value
  assign link_rd = link_vld_rd_q ? link_rd_q : (PTR_W'(link_rd_idx_q) + PTR_W'(1));

  // execution: head updates, write-back and response
  always_comb begin
    stack_head_d = stack_head_q;
    free_head_d  = free_head_q;
    data_we      = 1'b0;
    data_wa      = IDX_W'(free_head_q);
    data_wd      = value_q;
    link_we      = 1'b0;
    link_wa      = IDX_W'(free_head_q);
    link_wd      = END_MARK;
    done_d       = 1'b0;
    rd_val_d     = '0;
    status_d     = STATUS_OK;
    now_empty_d  = 1'b1;
    now_full_d   = !is_slot(free_head_q);
    case (state_q)
      ST_EXEC: begin
        done_d = 1'b1;
        if (!sel_ok_q) begin
          if (mode_q != MODE_NOP) status_d = STATUS_EMPTY;
        end else begin
          case (mode_e'(mode_q))
            MODE_PUSH: begin
              if (!is_slot(free_head_q)) begin
                status_d = STATUS_FULL;
              end else begin
                free_head_d         = link_rd;
                data_we             = 1'b1;
                link_we             = 1'b1;
                link_wd             = is_slot(top_q) ? top_q : END_MARK;
                stack_head_d[sel_q] = free_head_q;
              end
            end
            MODE_POP: begin
              if (!is_slot(top_q)) begin
                status_d = STATUS_EMPTY;
              end else begin
                rd_val_d            = VALUE_W'(data_rd_q);
                stack_head_d[sel_q] = is_slot(link_rd) ? link_rd : END_MARK;
                link_we             = 1'b1;
                link_wa             = IDX_W'(top_q);
                link_wd             = is_slot(free_head_q) ? free_head_q : END_MARK;
                free_head_d         = top_q;
              end
            end
            MODE_PEEK: begin
              if (!is_slot(top_q)) status_d = STATUS_EMPTY;
              else rd_val_d = VALUE_W'(data_rd_q);
            end
            default: ;
          endcase
          now_empty_d = !is_slot(stack_head_d[sel_q]);
        end
        now_full_d = !is_slot(free_head_d);
      end
      default: ;
    endcase
  end

  // control and response registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_head_q <= '0;
      for (int i = 0; i < NUM_STACKS; i++) stack_head_q[i] <= END_MARK;
      link_vld_q  <= '0;
      done_q      <= 1'b0;
      status_q    <= STATUS_OK;
      now_empty_q <= 1'b1;
      now_full_q  <= 1'b0;
      rd_val_q    <= '0;
    end else begin
      state_q      <= state_d;
      free_head_q  <= free_head_d;
      stack_head_q <= stack_head_d;
      if (link_we) link_vld_q[link_wa] <= 1'b1;
      done_q       <= done_d;
      status_q     <= status_d;
      now_empty_q  <= now_empty_d;
      now_full_q   <= now_full_d;
      rd_val_q     <= rd_val_d;
    end
  end

  // request capture and memory reads at the accepting edge
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q        <= mode_i;
      sel_q         <= STK_W'(stack_sel_i);
      sel_ok_q      <= sel_ok;
      value_q       <= push_value_i[DATA_WIDTH-1:0];
      data_rd_q     <= data_mem[IDX_W'(top_in)];
      link_rd_q     <= link_mem[link_ra_idx];
      link_vld_rd_q <= link_vld_q[link_ra_idx];
      link_rd_idx_q <= link_ra_idx;
    end
  end

  // memory writes
  always_ff @(posedge clk_i) begin
    if (data_we) data_mem[data_wa] <= data_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
  end

  assign done_o            = done_q;
  assign read_value_o      = rd_val_q;
  assign status_o          = status_q;
  assign stack_now_empty_o = now_empty_q;
  assign pool_now_full_o   = now_full_q;

endmodule

// ===== tb/tb_shared_pool_multi_stack_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_shared_pool_multi_stack_core: self-checking bench for the multi-stack core
// Drives push, pop, peek and the unused opcode on all stacks through the
// start/busy handshake. A scoreboard keeps its own image of the slot pool and
// the free list and checks every response in order. Random traffic alternates
// fill, drain and balanced stretches, so both pool full and empty stacks are
// exercised, under three idle settings on the request side.
// ----------------------------------------------------------------------------
module tb_shared_pool_multi_stack_core;
  import spms_pkg::*;

  localparam int                CYCLE_LIMIT = 200000;

  // expected response of one transaction
  typedef struct {
    logic [VALUE_W-1:0] value;
    status_e            status;
    logic               stack_empty;
    logic               pool_full;
  } stack_resp_t;

  // --------------------------------------------------------------------------
  // scoreboard: shadow copy of the pool, free list and stack tops
  // --------------------------------------------------------------------------
  class stack_pool_scoreboard;
    data_t       slot_word [POOL_SLOTS];
    ptr_t        slot_next [POOL_SLOTS];
    ptr_t        top_of    [NUM_STACKS];
    ptr_t        free_top;
    stack_resp_t pending_resp[$];
    int          errors, n_checked, n_push, n_pop, n_peek, n_full, n_empty;

    function new();
      for (int i = 0; i < POOL_SLOTS; i++) begin
        slot_word[i] = '0;
        slot_next[i] = ptr_t'(i + 1);
      end
      foreach (top_of[i]) top_of[i] = END_MARK;
      free_top = '0;
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // work out the response of an accepted transaction and update the image
    function void note_request(input logic [MODE_W-1:0] mode,
                               input logic [SEL_W-1:0] sel,
                               input logic [VALUE_W-1:0] word);
      stack_resp_t r;
      ptr_t        top, slot, nxt;
      r.value       = '0;
      r.status      = STATUS_OK;
      r.stack_empty = 1'b1;
      if (int'(sel) >= NUM_STACKS) begin
        // stack outside the configured set: always empty, never pushed
        if (mode != MODE_NOP) r.status = STATUS_EMPTY;
      end else begin
        top = top_of[sel];
        case (mode)
          MODE_PUSH: begin
            n_push++;
            if (free_top >= END_MARK) begin
              r.status = STATUS_FULL;
            end else begin
              slot            = free_top;
              free_top        = slot_next[slot];
              slot_word[slot] = word[DATA_WIDTH-1:0];
              slot_next[slot] = (top < END_MARK) ? top : END_MARK;
              top_of[sel]     = slot;
            end
          end
          MODE_POP, MODE_PEEK: begin
            if (mode == MODE_POP) n_pop++; else n_peek++;
            if (top >= END_MARK) begin
              r.status = STATUS_EMPTY;
            end else begin
              r.value = VALUE_W'(slot_word[top]);
              if (mode == MODE_POP) begin
                // unlink the top and return its slot to the head of the free list
                nxt            = slot_next[top];
                top_of[sel]    = (nxt < END_MARK) ? nxt : END_MARK;
                slot_next[top] = (free_top < END_MARK) ? free_top : END_MARK;
                free_top       = top;
              end
            end
          end
          default: ;
        endcase
        r.stack_empty = (top_of[sel] >= END_MARK);
      end
      r.pool_full = (free_top >= END_MARK);
      if (r.status == STATUS_FULL)  n_full++;
      if (r.status == STATUS_EMPTY) n_empty++;
      pending_resp.push_back(r);
    endfunction

    // compare one response with the oldest expectation
    task check_response(input logic [VALUE_W-1:0] value, input logic [STATUS_W-1:0] status,
                        input logic stack_empty, input logic pool_full);
      stack_resp_t r;
      if (pending_resp.size() == 0) begin
        report("response with no transaction outstanding");
      end else begin
        r = pending_resp.pop_front();
        n_checked++;
        if (value !== r.value)
          report($sformatf("read_value %h, expected %h", value, r.value));
        if (status !== r.status)
          report($sformatf("status %0d, expected %0d", status, r.status));
        if (stack_empty !== r.stack_empty)
          report($sformatf("stack_now_empty %b, expected %b", stack_empty, r.stack_empty));
        if (pool_full !== r.pool_full)
          report($sformatf("pool_now_full %b, expected %b", pool_full, r.pool_full));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [MODE_W-1:0]  mode_i;
  logic [SEL_W-1:0]   stack_sel_i;
  logic [VALUE_W-1:0] push_value_i;
  logic               done_o;
  logic [VALUE_W-1:0] read_value_o;
  logic [STATUS_W-1:0] status_o;
  logic               stack_now_empty_o;
  logic               pool_now_full_o;

  stack_pool_scoreboard sb = new();
  int unsigned          send_gap_pct;
  int unsigned          cycle_cnt;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  shared_pool_multi_stack_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .mode_i            (mode_i),
    .stack_sel_i       (stack_sel_i),
    .push_value_i      (push_value_i),
    .done_o            (done_o),
    .read_value_o      (read_value_o),
    .status_o          (status_o),
    .stack_now_empty_o (stack_now_empty_o),
    .pool_now_full_o   (pool_now_full_o)
  );

  // --------------------------------------------------------------------------
  // monitor: responses and accepted transactions, sampled at the clock edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni) begin
      if (done_o)
        sb.check_response(read_value_o, status_o, stack_now_empty_o, pool_now_full_o);
      if (start_i && !busy_o)
        sb.note_request(mode_i, stack_sel_i, push_value_i);
    end
  end

  // hang guard
  initial begin
    cycle_cnt = 0;
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("tb_shared_pool_multi_stack_core NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // driver tasks
  // --------------------------------------------------------------------------
  // present one transaction and hold it until the core takes it
  task automatic issue_op(input logic [MODE_W-1:0] m, input logic [SEL_W-1:0] s,
                          input logic [VALUE_W-1:0] v);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    mode_i       <= m;
    stack_sel_i  <= s;
    push_value_i <= v;
    // busy_o only moves on the rising edge, so the falling edge sees its next value
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // one random transaction; push_pct sets the lean towards filling the pool
  task automatic issue_random(input int unsigned push_pct);
    int unsigned      r;
    logic [MODE_W-1:0] m;
    r = $urandom_range(0, 99);
    if (r < 4)                 m = MODE_NOP;
    else if (r < 4 + push_pct) m = MODE_PUSH;
    else if (r % 3 == 0)       m = MODE_PEEK;
    else                       m = MODE_POP;
    issue_op(m, SEL_W'($urandom_range(0, NUM_STACKS - 1)), pick_word());
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap_pct [3];
    int unsigned lean    [3];
    int          waited;
    gap_pct = '{7, 54, 0};
    lean    = '{85, 15, 50};   // fill, drain, balanced
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    mode_i       <= MODE_PUSH;
    stack_sel_i  <= '0;
    push_value_i <= '0;
    send_gap_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty stacks, data extremes, unused opcode, draining to empty
    issue_op(MODE_PEEK, 2'd0, '0);
    issue_op(MODE_POP,  2'd0, '1);
    issue_op(MODE_POP,  2'd3, '0);
    issue_op(MODE_PEEK, 2'd3, '0);
    issue_op(MODE_PUSH, 2'd0, 32'h0000_0000);
    issue_op(MODE_PUSH, 2'd0, 32'hFFFF_FFFF);
    issue_op(MODE_PEEK, 2'd0, '0);
    issue_op(MODE_PUSH, 2'd1, 32'h8000_0000);
    issue_op(MODE_PUSH, 2'd2, 32'h7FFF_FFFF);
    issue_op(MODE_PUSH, 2'd3, 32'h5A5A_A5A5);
    issue_op(MODE_NOP,  2'd1, '1);
    issue_op(MODE_POP,  2'd0, '0);
    issue_op(MODE_POP,  2'd0, '0);
    issue_op(MODE_POP,  2'd0, '0);
    issue_op(MODE_PEEK, 2'd1, '0);
    issue_op(MODE_POP,  2'd1, '0);
    issue_op(MODE_POP,  2'd2, '0);
    issue_op(MODE_PUSH, 2'd2, 32'h1234_5678);
    issue_op(MODE_POP,  2'd3, '0);
    issue_op(MODE_PEEK, 2'd3, '0);
    issue_op(MODE_NOP,  2'd2, '0);
    issue_op(MODE_POP,  2'd2, '0);

    // random: each idle setting runs a fill, a drain and a balanced stretch
    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = gap_pct[ph];
      for (int b = 0; b < 3; b++)
        repeat (90) issue_random(lean[b]);
    end
    start_i <= 1'b0;

    // drain outstanding responses, then allow for the pipeline
    waited = 0;
    while (sb.pending_resp.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (sb.pending_resp.size() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.pending_resp.size()));

    $display("checked %0d responses: %0d push, %0d pop, %0d peek",
             sb.n_checked, sb.n_push, sb.n_pop, sb.n_peek);
    $display("pool-full refusals %0d, empty-stack answers %0d, mismatches %0d",
             sb.n_full, sb.n_empty, sb.errors);
    if (sb.errors == 0)
      $display("tb_shared_pool_multi_stack_core OK");
    else
      $display("tb_shared_pool_multi_stack_core NOT OK");
    $finish;
  end

endmodule
